// File: rtl/mcpe_pkg.sv
// Shared types and constants for the MIME charset parameter extractor.
package mcpe_pkg;

  localparam int unsigned MaxValueBytes = 32;

  typedef enum logic [1:0] {
    StCharByte = 2'd0,
    StEmpty    = 2'd1,
    StNone     = 2'd2,
    StTooLong  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_header;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] value_byte;
    logic       last_result;
  } out_item_t;

endpackage

// File: rtl/mcpe_parser.sv
// Byte-wise Content-Type parser that finds the charset value and writes it to the value store.
module mcpe_parser import mcpe_pkg::*; #(
  parameter int unsigned MAX_VALUE_BYTES = MaxValueBytes,
  localparam int unsigned AW = $clog2(MAX_VALUE_BYTES),
  localparam int unsigned LW = $clog2(MAX_VALUE_BYTES + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  in_item_t      item_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output status_e       job_status_o,
  output logic [LW-1:0] job_len_o
);

  localparam logic [3:0] PhLead       = 4'd0;
  localparam logic [3:0] PhType       = 4'd1;
  localparam logic [3:0] PhSubtype    = 4'd2;
  localparam logic [3:0] PhParamWs    = 4'd3;
  localparam logic [3:0] PhName       = 4'd4;
  localparam logic [3:0] PhValueStart = 4'd5;
  localparam logic [3:0] PhQuoted     = 4'd6;
  localparam logic [3:0] PhAfterQuote = 4'd7;
  localparam logic [3:0] PhUnquoted   = 4'd8;
  localparam logic [3:0] PhDone       = 4'd9;
  localparam logic [3:0] PhFail       = 4'd10;

  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDel       = 8'h7F;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChEq        = 8'h3D;
  localparam logic [7:0] ChBackslash = 8'h5C;

  localparam logic [2:0] KwLen = 3'd7;
  localparam logic [7:0][7:0] Keyword = {8'h00, "t", "e", "s", "r", "a", "h", "c"};

  localparam logic [LW-1:0] MaxLen = LW'(MAX_VALUE_BYTES);

  function automatic logic is_token(input logic [7:0] c);
    return c == 8'h21 || (c >= 8'h23 && c <= 8'h27) || c == 8'h2A || c == 8'h2B ||
           c == 8'h2D || c == 8'h2E || c == 8'h5E || c == 8'h5F || c == 8'h60 ||
           c == 8'h7C || c == 8'h7E || (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  logic [3:0]    phase_q, phase_d;
  logic          failed_q, failed_d;
  logic          nonempty_q, nonempty_d;
  logic          sub_ws_q, sub_ws_d;
  logic [2:0]    match_q, match_d;
  logic          mismatch_q, mismatch_d;
  logic          esc_q, esc_d;
  logic [LW-1:0] vlen_q, vlen_d;
  logic [LW-1:0] tlen_q, tlen_d;
  logic          bad_in_q, bad_in_d;
  logic          bad_pend_q, bad_pend_d;
  logic          tail_q, tail_d;
  logic          found_q, found_d;

  logic [7:0]    b;
  logic [7:0]    lc;
  logic          ws;
  logic          qtok;
  logic          tok;

  assign b    = item_i.in_byte;
  assign lc   = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  assign ws   = b == ChTab || b == ChLf || b == ChCr || b == ChSpace;
  assign qtok = b == ChTab || (b >= ChSpace && b != ChDel);
  assign tok  = is_token(b);

  always_comb begin
    logic          ap;
    logic          ap_ws;
    logic          ap_solid;
    logic          trim_after;
    logic          unq;
    logic [LW-1:0] end_len;

    phase_d      = phase_q;
    failed_d     = failed_q;
    nonempty_d   = nonempty_q;
    sub_ws_d     = sub_ws_q;
    match_d      = match_q;
    mismatch_d   = mismatch_q;
    esc_d        = esc_q;
    vlen_d       = vlen_q;
    tlen_d       = tlen_q;
    bad_in_d     = bad_in_q;
    bad_pend_d   = bad_pend_q;
    tail_d       = tail_q;
    found_d      = found_q;
    ap           = 1'b0;
    ap_ws        = 1'b0;
    ap_solid     = 1'b0;
    trim_after   = 1'b0;
    unq          = 1'b0;
    end_len      = '0;
    wr_en_o      = 1'b0;
    wr_addr_o    = vlen_q[AW-1:0];
    wr_data_o    = b;
    job_status_o = StNone;
    job_len_o    = '0;

    if (step_i) begin
      unique case (phase_q)
        PhLead, PhType: begin
          if (!(phase_q == PhLead && ws)) begin
            phase_d = PhType;
            if (b == ChSlash) begin
              if (!nonempty_q) begin
                phase_d = PhFail;
              end else begin
                phase_d    = PhSubtype;
                nonempty_d = 1'b0;
                sub_ws_d   = 1'b0;
              end
            end else if (tok) begin
              nonempty_d = 1'b1;
            end else begin
              phase_d = PhFail;
            end
          end
        end
        PhSubtype: begin
          if (b == ChSemi) begin
            phase_d = nonempty_q ? PhParamWs : PhFail;
          end else if (ws) begin
            if (!nonempty_q) phase_d = PhFail;
            else sub_ws_d = 1'b1;
          end else if (tok && !sub_ws_q) begin
            nonempty_d = 1'b1;
          end else begin
            phase_d = PhFail;
          end
        end
        PhParamWs: begin
          if (!(ws || b == ChSemi)) begin
            match_d    = '0;
            mismatch_d = 1'b0;
            if (b == ChEq) begin
              mismatch_d = 1'b1;
              phase_d    = PhValueStart;
            end else begin
              phase_d = PhName;
              if (lc == Keyword[0]) match_d = 3'd1;
              else mismatch_d = 1'b1;
            end
          end
        end
        PhName: begin
          if (b == ChSemi) begin
            phase_d = PhParamWs;
          end else if (b == ChEq) begin
            if (match_q != KwLen) mismatch_d = 1'b1;
            phase_d = PhValueStart;
          end else if (match_q < KwLen && lc == Keyword[match_q]) begin
            match_d = match_q + 3'd1;
          end else begin
            mismatch_d = 1'b1;
          end
        end
        PhValueStart: begin
          vlen_d     = '0;
          tlen_d     = '0;
          bad_in_d   = 1'b0;
          bad_pend_d = 1'b0;
          esc_d      = 1'b0;
          tail_d     = 1'b0;
          if (b == ChQuote) begin
            phase_d = PhQuoted;
          end else begin
            phase_d = PhUnquoted;
            unq     = 1'b1;
          end
        end
        PhQuoted: begin
          if (esc_q) begin
            esc_d = 1'b0;
            ap    = 1'b1;
            if (ws) begin
              ap_ws = 1'b1;
            end else begin
              ap_solid   = 1'b1;
              trim_after = 1'b1;
              tail_d     = 1'b0;
            end
          end else if (ws) begin
            ap    = 1'b1;
            ap_ws = 1'b1;
          end else if (b == ChBackslash) begin
            if (bad_pend_q) begin
              bad_in_d   = 1'b1;
              bad_pend_d = 1'b0;
            end
            esc_d  = 1'b1;
            tlen_d = vlen_q;
            tail_d = 1'b1;
          end else if (b == ChQuote) begin
            if (!mismatch_q && !bad_in_q && !bad_pend_q) begin
              found_d = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhAfterQuote;
            end
          end else begin
            ap         = 1'b1;
            ap_solid   = 1'b1;
            trim_after = 1'b1;
            tail_d     = 1'b0;
          end
        end
        PhAfterQuote: begin
          if (b == ChSemi) phase_d = PhParamWs;
        end
        PhUnquoted: unq = 1'b1;
        PhDone: ;
        default: begin
          phase_d  = PhFail;
          failed_d = 1'b1;
        end
      endcase

      if (unq) begin
        if (b == ChSemi) begin
          if (tlen_d == '0) begin
            phase_d = PhParamWs;
          end else if (!mismatch_d && !bad_in_d) begin
            found_d = 1'b1;
            vlen_d  = tlen_d;
            phase_d = PhDone;
          end else begin
            phase_d = PhParamWs;
          end
        end else if (ws) begin
          ap    = 1'b1;
          ap_ws = 1'b1;
        end else begin
          ap         = 1'b1;
          ap_solid   = 1'b1;
          trim_after = 1'b1;
        end
      end

      if (ap_solid && bad_pend_d) begin
        bad_in_d   = 1'b1;
        bad_pend_d = 1'b0;
      end
      if (ap) begin
        if (vlen_d < MaxLen) begin
          wr_en_o   = 1'b1;
          wr_addr_o = vlen_d[AW-1:0];
        end
        if (vlen_d <= MaxLen) vlen_d = vlen_d + LW'(1);
      end
      if (ap_ws && !qtok) bad_pend_d = 1'b1;
      if (ap_solid && !qtok) bad_in_d = 1'b1;
      if (trim_after) tlen_d = vlen_d;
      if (phase_d == PhFail) failed_d = 1'b1;

      if (item_i.end_of_header) begin
        if (phase_d == PhQuoted) begin
          end_len = tlen_d;
          if (tail_d) begin
            if (end_len < MaxLen) begin
              wr_en_o   = 1'b1;
              wr_addr_o = end_len[AW-1:0];
              wr_data_o = ChBackslash;
            end
            if (end_len <= MaxLen) end_len = end_len + LW'(1);
          end
          if (!mismatch_d && !bad_in_d) begin
            found_d = 1'b1;
            vlen_d  = end_len;
          end
        end else if (phase_d == PhUnquoted && tlen_d != '0) begin
          if (!mismatch_d && !bad_in_d) begin
            found_d = 1'b1;
            vlen_d  = tlen_d;
          end
        end

        if (!found_d || failed_d) job_status_o = StNone;
        else if (vlen_d == '0) job_status_o = StEmpty;
        else if (vlen_d > MaxLen) job_status_o = StTooLong;
        else job_status_o = StCharByte;
        job_len_o = vlen_d;

        phase_d    = PhLead;
        failed_d   = 1'b0;
        nonempty_d = 1'b0;
        sub_ws_d   = 1'b0;
        match_d    = '0;
        mismatch_d = 1'b0;
        esc_d      = 1'b0;
        vlen_d     = '0;
        tlen_d     = '0;
        bad_in_d   = 1'b0;
        bad_pend_d = 1'b0;
        tail_d     = 1'b0;
        found_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhLead;
      failed_q   <= 1'b0;
      nonempty_q <= 1'b0;
      sub_ws_q   <= 1'b0;
      match_q    <= '0;
      mismatch_q <= 1'b0;
      esc_q      <= 1'b0;
      vlen_q     <= '0;
      tlen_q     <= '0;
      bad_in_q   <= 1'b0;
      bad_pend_q <= 1'b0;
      tail_q     <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      failed_q   <= failed_d;
      nonempty_q <= nonempty_d;
      sub_ws_q   <= sub_ws_d;
      match_q    <= match_d;
      mismatch_q <= mismatch_d;
      esc_q      <= esc_d;
      vlen_q     <= vlen_d;
      tlen_q     <= tlen_d;
      bad_in_q   <= bad_in_d;
      bad_pend_q <= bad_pend_d;
      tail_q     <= tail_d;
      found_q    <= found_d;
    end
  end

endmodule

// File: rtl/mime_charset_param_extractor_core.sv
// Top level of the MIME charset parameter extractor: parser, value store and result burst.
// The block takes one header byte per cycle while in_ready_o is high and parses it at once.
// On the byte that ends a header it answers with a burst: each charset value byte as its own
// item, or one status item, and the last item is flagged. Once the final byte is accepted,
// the burst is registered as active or pending; each item is read from the store into a
// read register, then into the output register. Bursts leave at one item per cycle while
// the output is not stalled, from a two-bank value store, so the next header is parsed
// while the previous burst drains; input stalls only when a second header ends before the
// burst ahead is read out. A value longer than MAX_VALUE_BYTES is reported as too long.
module mime_charset_param_extractor_core import mcpe_pkg::*; #(
  parameter int unsigned MAX_VALUE_BYTES = MaxValueBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_VALUE_BYTES);
  localparam int unsigned LW = $clog2(MAX_VALUE_BYTES + 2);
  localparam int unsigned MemDepth = 2 ** (AW + 1);

  logic          in_acc;
  logic          job_new;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  status_e       job_status;
  logic [LW-1:0] job_len;

  logic          wr_bank_q;
  logic          act_q;
  logic          act_bank_q;
  status_e       act_status_q;
  logic [LW-1:0] act_len_q;
  logic [AW-1:0] act_idx_q;
  logic          pend_v_q;
  logic          pend_bank_q;
  status_e       pend_status_q;
  logic [LW-1:0] pend_len_q;

  logic          s1_v_q;
  status_e       s1_status_q;
  logic          s1_last_q;
  logic [7:0]    rd_data_q;
  logic          out_v_q;
  out_item_t     out_q;

  logic [7:0]    mem_q [MemDepth];

  logic          s1_move;
  logic          rd_fire;
  logic          last_issue;
  logic          slot_free;

  assign in_ready_o = !pend_v_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign job_new    = in_acc && in_data_i.end_of_header;

  mcpe_parser #(
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .item_i      (in_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_status_o(job_status),
    .job_len_o   (job_len)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en && in_acc) begin
      mem_q[{wr_bank_q, wr_addr}] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rd_data_q <= mem_q[{act_bank_q, act_idx_q}];
    end
  end

  assign s1_move    = s1_v_q && (!out_v_q || out_ready_i);
  assign rd_fire    = act_q && (!s1_v_q || s1_move);
  assign last_issue = (act_status_q != StCharByte) ||
                      (LW'(act_idx_q) + LW'(1) == act_len_q);
  assign slot_free  = !act_q || (rd_fire && last_issue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_bank_q <= 1'b0;
      act_q     <= 1'b0;
      pend_v_q  <= 1'b0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (job_new) wr_bank_q <= !wr_bank_q;
      if (slot_free) begin
        if (pend_v_q) begin
          act_q    <= 1'b1;
          pend_v_q <= 1'b0;
        end else begin
          act_q <= job_new;
        end
      end else if (job_new) begin
        pend_v_q <= 1'b1;
      end
      if (rd_fire) s1_v_q <= 1'b1;
      else if (s1_move) s1_v_q <= 1'b0;
      if (s1_move) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      act_idx_q <= '0;
      if (pend_v_q) begin
        act_bank_q   <= pend_bank_q;
        act_status_q <= pend_status_q;
        act_len_q    <= pend_len_q;
      end else begin
        act_bank_q   <= wr_bank_q;
        act_status_q <= job_status;
        act_len_q    <= job_len;
      end
    end else if (rd_fire) begin
      act_idx_q <= act_idx_q + AW'(1);
    end
    if (!slot_free && job_new) begin
      pend_bank_q   <= wr_bank_q;
      pend_status_q <= job_status;
      pend_len_q    <= job_len;
    end
    if (rd_fire) begin
      s1_status_q <= act_status_q;
      s1_last_q   <= last_issue;
    end
    if (s1_move) begin
      out_q.status      <= s1_status_q;
      out_q.value_byte  <= (s1_status_q == StCharByte) ? rd_data_q : 8'h00;
      out_q.last_result <= s1_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_pend_needs_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> act_q)
    else $error("pending burst without an active burst");

  a_pend_other_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && act_q) |-> (pend_bank_q != act_bank_q))
    else $error("pending and active bursts share a store bank");

  a_no_write_under_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && in_acc && act_q) |-> (wr_bank_q != act_bank_q))
    else $error("parser writes the bank that is being read out");

  a_status_item_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.status != StCharByte) |-> (out_q.last_result && out_q.value_byte == 8'h00))
    else $error("status item is not a single last item with zero data");

  a_s1_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_ready_i) |=> s1_v_q)
    else $error("staged result lost while output stalled");

endmodule
